@@ sv/gtri_pkg.sv @@
`timescale 1ns / 1ps
package gtri_pkg;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [2:0] CFG_ROW_COUNT     = 3'd0;
    localparam logic [2:0] CFG_COLUMN_COUNT  = 3'd1;
    localparam logic [2:0] CFG_TIME_START    = 3'd2;
    localparam logic [2:0] CFG_TIME_END      = 3'd3;
    localparam logic [2:0] CFG_INV_TIME_STEP = 3'd4;
    localparam logic [2:0] CFG_SPACE_OFFSET  = 3'd5;
    localparam logic [2:0] CFG_INV_CELL_SIZE = 3'd6;
    localparam logic [2:0] CFG_TEMP_GAIN     = 3'd7;

    localparam int GRID_AW = 16;
    localparam logic signed [32:0] ONE_Q16 = 33'sd65536;

    typedef struct packed {
        logic               cmd;
        logic [15:0]        grid_address;
        logic signed [31:0] grid_temp;
        logic signed [31:0] grid_vel_x;
        logic signed [31:0] grid_vel_y;
        logic signed [31:0] query_time;
        logic signed [31:0] query_x;
        logic signed [31:0] query_y;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] temperature;
        logic signed [31:0] velocity_x;
        logic signed [31:0] velocity_y;
        logic               outside_window;
    } t_out_item;

endpackage

@@ sv/gtri_in_if.sv @@
`timescale 1ns / 1ps
interface gtri_in_if;
    logic               valid;
    logic               ready;
    gtri_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ sv/gtri_out_if.sv @@
`timescale 1ns / 1ps
interface gtri_out_if;
    logic                valid;
    logic                ready;
    gtri_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ sv/gtri_ram.sv @@
`timescale 1ns / 1ps
module gtri_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ sv/grid_trilinear_interpolator.sv @@
`timescale 1ns / 1ps
// Throughput: one item per cycle; the whole pipeline halts while a result waits.
// Each corner has its own copy of the grid memory, so all eight reads happen in the same cycle.
// Writes reach the memories at the read stage, keeping them in order with queries.
// Reset (synchronous, active low) clears valid bits and loads register defaults;
// grid contents are undefined until written.
module grid_trilinear_interpolator #(
    parameter int TIME_SLICES = 16,
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLUMNS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gtri_in_if.sink     i_in,
    gtri_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    localparam int TIW = (TIME_SLICES > 2) ? $clog2(TIME_SLICES) : 1;
    localparam int XIW = (MAX_COLUMNS > 2) ? $clog2(MAX_COLUMNS) : 1;
    localparam int YIW = (MAX_ROWS > 2) ? $clog2(MAX_ROWS) : 1;
    localparam int AW  = gtri_pkg::GRID_AW;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if ((&v[65:31]) || !(|v[65:31])) begin
            return v[31:0];
        end
        return v[65] ? 32'sh80000000 : 32'sh7FFFFFFF;
    endfunction

    // Clamp the floor index into [0, last] and form the fraction against it.
    function automatic logic [15:0] clamp_idx(input logic signed [48:0] g,
                                              input logic [15:0] last);
        logic signed [32:0] i;
        i = g[48:16];
        if (i < 0) begin
            return 16'd0;
        end
        if (i > $signed({17'd0, last})) begin
            return last;
        end
        return i[15:0];
    endfunction

    function automatic logic signed [31:0] frac_of(input logic signed [48:0] g,
                                                   input logic [15:0] idx);
        logic signed [65:0] d;
        d = {{17{g[48]}}, g} - $signed({34'd0, idx, 16'd0});
        return sat32(d);
    endfunction

    // configuration registers
    logic [6:0]         r_rows_cfg, r_cols_cfg;
    logic signed [31:0] r_t0, r_t1, r_inv_t, r_off, r_inv_c, r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg <= 7'd64;
            r_cols_cfg <= 7'd64;
            r_t0       <= 32'sd0;
            r_t1       <= 32'sh7FFFFFFF;
            r_inv_t    <= 32'sd65536;
            r_off      <= 32'sd0;
            r_inv_c    <= 32'sd65536;
            r_gain     <= 32'sd65536;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                gtri_pkg::CFG_ROW_COUNT:     r_rows_cfg <= i_cfg_data[6:0];
                gtri_pkg::CFG_COLUMN_COUNT:  r_cols_cfg <= i_cfg_data[6:0];
                gtri_pkg::CFG_TIME_START:    r_t0 <= i_cfg_data;
                gtri_pkg::CFG_TIME_END:      r_t1 <= i_cfg_data;
                gtri_pkg::CFG_INV_TIME_STEP: r_inv_t <= i_cfg_data;
                gtri_pkg::CFG_SPACE_OFFSET:  r_off <= i_cfg_data;
                gtri_pkg::CFG_INV_CELL_SIZE: r_inv_c <= i_cfg_data;
                gtri_pkg::CFG_TEMP_GAIN:     r_gain <= i_cfg_data;
            endcase
        end
    end

    logic [15:0] n_rows, n_cols;

    always_comb begin
        if (r_rows_cfg < 7'd2) begin
            n_rows = 16'd2;
        end else if (16'(r_rows_cfg) > 16'(MAX_ROWS)) begin
            n_rows = 16'(MAX_ROWS);
        end else begin
            n_rows = 16'(r_rows_cfg);
        end
        if (r_cols_cfg < 7'd2) begin
            n_cols = 16'd2;
        end else if (16'(r_cols_cfg) > 16'(MAX_COLUMNS)) begin
            n_cols = 16'(MAX_COLUMNS);
        end else begin
            n_cols = 16'(r_cols_cfg);
        end
    end

    logic adv;
    logic r_l_v;
    assign adv        = !r_l_v || o_out.ready;
    assign i_in.ready = adv;

    // write payload travels with every item down to the memory stage
    logic [AW-1:0] r_a_wa, r_b_wa, r_c_wa, r_d_wa, r_e_wa, r_f_wa, r_g_wa;
    logic [95:0]   r_a_wd, r_b_wd, r_c_wd, r_d_wd, r_e_wd, r_f_wd, r_g_wd;
    logic r_a_v, r_b_v, r_c_v, r_d_v, r_e_v, r_f_v, r_g_v, r_h_v, r_i_v, r_j_v, r_k_v;
    logic r_a_q, r_b_q, r_c_q, r_d_q, r_e_q, r_f_q, r_g_q;
    logic r_b_o, r_c_o, r_d_o, r_e_o, r_f_o, r_g_o, r_h_o, r_i_o, r_j_o, r_k_o;

    logic signed [31:0] r_a_t, r_a_x, r_a_y;
    logic signed [32:0] r_b_dt, r_b_sx, r_b_sy;
    logic signed [48:0] r_c_gt, r_c_gx, r_c_gy;
    logic [TIW-1:0]     r_d_it;
    logic [XIW-1:0]     r_d_ix;
    logic [YIW-1:0]     r_d_iy;
    logic signed [31:0] r_d_ft, r_d_fx, r_d_fy;
    logic signed [31:0] r_e_ptx [4];
    logic signed [31:0] r_e_wy0, r_e_wy1;
    logic [15:0]        r_e_a, r_e_st;
    logic [XIW-1:0]     r_e_ix;
    logic signed [31:0] r_f_w [8];
    logic [15:0]        r_f_base, r_f_st;
    logic signed [31:0] r_g_w [8];
    logic [AW-1:0]      r_g_addr [8];
    logic signed [31:0] r_h_w [8];
    logic [95:0]        ram_rd [8];
    logic signed [47:0] r_i_p [3][8];
    logic signed [48:0] r_j_s [3][4];
    logic signed [31:0] r_k_s [3];
    gtri_pkg::t_out_item r_l;

    // combinational next values
    logic signed [64:0] n_pt, n_px, n_py;
    logic [15:0]        n_it, n_ix, n_iy;
    logic signed [31:0] n_wt [2], n_wx [2], n_wy [2];
    logic signed [63:0] n_ptx [4];
    logic signed [63:0] n_pw [8];
    logic signed [63:0] n_pv [3][8];
    logic signed [63:0] n_pg;

    always_comb begin
        n_pt = r_b_dt * r_inv_t;
        n_px = r_b_sx * r_inv_c;
        n_py = r_b_sy * r_inv_c;
        n_it = clamp_idx(r_c_gt, 16'(TIME_SLICES - 2));
        n_ix = clamp_idx(r_c_gx, n_cols - 16'd2);
        n_iy = clamp_idx(r_c_gy, n_rows - 16'd2);
        n_wt[0] = sat32(66'(gtri_pkg::ONE_Q16) - 66'(r_d_ft));
        n_wt[1] = r_d_ft;
        n_wx[0] = sat32(66'(gtri_pkg::ONE_Q16) - 66'(r_d_fx));
        n_wx[1] = r_d_fx;
        n_wy[0] = sat32(66'(gtri_pkg::ONE_Q16) - 66'(r_d_fy));
        n_wy[1] = r_d_fy;
        // time bit is the high bit of the pair index, x bit the low one
        for (int p = 0; p < 4; p++) begin
            n_ptx[p] = n_wt[p >> 1] * n_wx[p & 1];
        end
        // corner k: bit 2 time, bit 1 y, bit 0 x
        for (int k = 0; k < 8; k++) begin
            n_pw[k] = r_e_ptx[((k >> 1) & 2) | (k & 1)] * (((k >> 1) & 1) != 0 ? r_e_wy1
                                                                                 : r_e_wy0);
        end
        for (int k = 0; k < 8; k++) begin
            n_pv[0][k] = $signed(ram_rd[k][31:0]) * r_h_w[k];
            n_pv[1][k] = $signed(ram_rd[k][63:32]) * r_h_w[k];
            n_pv[2][k] = $signed(ram_rd[k][95:64]) * r_h_w[k];
        end
        n_pg = r_k_s[0] * r_gain;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0; r_b_v <= 1'b0; r_c_v <= 1'b0; r_d_v <= 1'b0;
            r_e_v <= 1'b0; r_f_v <= 1'b0; r_g_v <= 1'b0; r_h_v <= 1'b0;
            r_i_v <= 1'b0; r_j_v <= 1'b0; r_k_v <= 1'b0; r_l_v <= 1'b0;
        end else if (adv) begin
            r_a_v <= i_in.valid;
            r_b_v <= r_a_v; r_c_v <= r_b_v; r_d_v <= r_c_v; r_e_v <= r_d_v;
            r_f_v <= r_e_v; r_g_v <= r_f_v;
            // writes end at the memory stage and bring no result
            r_h_v <= r_g_v && r_g_q;
            r_i_v <= r_h_v; r_j_v <= r_i_v; r_k_v <= r_j_v; r_l_v <= r_k_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_q  <= i_in.data.cmd == gtri_pkg::CMD_QUERY;
            r_a_wa <= i_in.data.grid_address;
            r_a_wd <= {i_in.data.grid_vel_y, i_in.data.grid_vel_x, i_in.data.grid_temp};
            r_a_t  <= i_in.data.query_time;
            r_a_x  <= i_in.data.query_x;
            r_a_y  <= i_in.data.query_y;

            r_b_q  <= r_a_q; r_b_wa <= r_a_wa; r_b_wd <= r_a_wd;
            r_b_o  <= (r_a_t >= r_t1) || (r_a_t < r_t0);
            r_b_dt <= 33'(r_a_t) - 33'(r_t0);
            r_b_sx <= 33'(r_off) + 33'(r_a_x);
            r_b_sy <= 33'(r_off) + 33'(r_a_y);

            r_c_q  <= r_b_q; r_c_wa <= r_b_wa; r_c_wd <= r_b_wd; r_c_o <= r_b_o;
            r_c_gt <= n_pt[64:16];
            r_c_gx <= n_px[64:16];
            r_c_gy <= n_py[64:16];

            r_d_q  <= r_c_q; r_d_wa <= r_c_wa; r_d_wd <= r_c_wd; r_d_o <= r_c_o;
            r_d_it <= n_it[TIW-1:0];
            r_d_ix <= n_ix[XIW-1:0];
            r_d_iy <= n_iy[YIW-1:0];
            r_d_ft <= frac_of(r_c_gt, n_it);
            r_d_fx <= frac_of(r_c_gx, n_ix);
            r_d_fy <= frac_of(r_c_gy, n_iy);

            r_e_q  <= r_d_q; r_e_wa <= r_d_wa; r_e_wd <= r_d_wd; r_e_o <= r_d_o;
            for (int p = 0; p < 4; p++) begin
                r_e_ptx[p] <= sat32(66'($signed(n_ptx[p][63:16])));
            end
            r_e_wy0 <= n_wy[0];
            r_e_wy1 <= n_wy[1];
            r_e_a   <= 16'(r_d_it) * n_rows + 16'(r_d_iy);
            r_e_st  <= n_rows * n_cols;
            r_e_ix  <= r_d_ix;

            r_f_q  <= r_e_q; r_f_wa <= r_e_wa; r_f_wd <= r_e_wd; r_f_o <= r_e_o;
            for (int k = 0; k < 8; k++) begin
                r_f_w[k] <= sat32(66'($signed(n_pw[k][63:16])));
            end
            r_f_base <= r_e_a * n_cols + 16'(r_e_ix);
            r_f_st   <= r_e_st;

            r_g_q  <= r_f_q; r_g_wa <= r_f_wa; r_g_wd <= r_f_wd; r_g_o <= r_f_o;
            for (int k = 0; k < 8; k++) begin
                r_g_w[k]    <= r_f_w[k];
                r_g_addr[k] <= r_f_base + (((k >> 2) & 1) != 0 ? r_f_st : 16'd0)
                             + (((k >> 1) & 1) != 0 ? n_cols : 16'd0) + 16'(k & 1);
            end

            r_h_o <= r_g_o;
            for (int k = 0; k < 8; k++) begin
                r_h_w[k] <= r_g_w[k];
            end

            r_i_o <= r_h_o;
            for (int g = 0; g < 3; g++) begin
                for (int k = 0; k < 8; k++) begin
                    r_i_p[g][k] <= n_pv[g][k][63:16];
                end
            end

            r_j_o <= r_i_o;
            for (int g = 0; g < 3; g++) begin
                for (int p = 0; p < 4; p++) begin
                    r_j_s[g][p] <= 49'(r_i_p[g][2*p]) + 49'(r_i_p[g][2*p+1]);
                end
            end

            r_k_o <= r_j_o;
            for (int g = 0; g < 3; g++) begin
                r_k_s[g] <= sat32(66'(r_j_s[g][0]) + 66'(r_j_s[g][1])
                                + 66'(r_j_s[g][2]) + 66'(r_j_s[g][3]));
            end

            r_l.outside_window <= r_k_o;
            r_l.temperature    <= r_k_o ? 32'sd0 : sat32(66'($signed(n_pg[63:16])));
            r_l.velocity_x     <= r_k_o ? 32'sd0 : r_k_s[1];
            r_l.velocity_y     <= r_k_o ? 32'sd0 : r_k_s[2];
        end
    end

    for (genvar c = 0; c < 8; c++) begin : g_corner
        gtri_ram #(
            .WIDTH (96),
            .DEPTH (1 << AW)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (adv && r_g_v && !r_g_q),
            .i_waddr (r_g_wa),
            .i_wdata (r_g_wd),
            .i_re    (adv),
            .i_raddr (r_g_addr[c]),
            .o_rdata (ram_rd[c])
        );
    end

    assign o_out.valid = r_l_v;
    assign o_out.data  = r_l;

`ifndef NO_ASSERTIONS
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_l_v && r_l.outside_window |->
            r_l.temperature == 0 && r_l.velocity_x == 0 && r_l.velocity_y == 0)
        else $error("outside result carries non-zero values");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready == (!o_out.valid || o_out.ready))
        else $error("input ready does not follow output stage");
    a_time_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_v |-> 32'(r_d_it) <= TIME_SLICES - 2)
        else $error("time index beyond last cell");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_l_v && !o_out.ready |=> $stable(r_h_w[0]) && $stable(r_g_addr[0]))
        else $error("pipeline moved during a stall");
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !r_l_v)
        else $error("result valid right after reset");
`endif
endmodule
